@@ rtl/core/mtr_pkg.sv @@
`default_nettype none

package mtr_pkg;

  localparam int STATE_DEPTH = 624;
  localparam int SHIFT_SPAN  = 397;
  localparam int AW          = $clog2(STATE_DEPTH);

  localparam logic [AW-1:0] LAST_POS  = AW'(STATE_DEPTH - 1);
  localparam logic [AW-1:0] SPAN      = AW'(SHIFT_SPAN);
  localparam logic [AW-1:0] WRAP_SPAN = AW'(STATE_DEPTH - SHIFT_SPAN);

  localparam logic [31:0] SEED_RESET = 32'd5489;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] TWIST_XOR  = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;
  localparam logic [31:0] UPPER_BIT  = 32'h8000_0000;
  localparam logic [31:0] LOWER_BITS = 32'h7FFF_FFFF;

  typedef logic [AW-1:0] addr_t;
  typedef logic [31:0]   word_t;

  function automatic addr_t next_pos(input addr_t p);
    next_pos = (p == LAST_POS) ? '0 : p + AW'(1);
  endfunction

  function automatic addr_t far_pos(input addr_t p);
    far_pos = (p < WRAP_SPAN) ? p + SPAN : p - WRAP_SPAN;
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    temper = y;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mtr_ram.sv @@
`default_nettype none

module mtr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mersenne_twister_rng_top.sv @@
// The three state reads of a beat go over two mirrored RAM ports. A new beat is accepted only
// in idle, not while a result waits at the output; after the far-read state the twisted word is
// written back and the tempered result registered once the output is free. A seeding beat
// (first after reset or reseed) writes each state word via the seed multiplier, then loads.
// Reset: seed register returns to 5489, generator unseeded, read position 0.
`default_nettype none

module mersenne_twister_rng_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        reseed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      value
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEED = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_FAR  = 2'd3;

  logic [1:0]          state, state_next;
  mtr_pkg::addr_t      pos;
  mtr_pkg::addr_t      idx;
  logic                seeded;
  logic                pending;
  logic [31:0]         seed_reg;
  mtr_pkg::word_t      prev;
  mtr_pkg::word_t      cur;
  mtr_pkg::word_t      nxt;

  mtr_pkg::word_t      rdata_a, rdata_b;
  mtr_pkg::addr_t      raddr_a, raddr_b, waddr, pos_adv;
  mtr_pkg::word_t      wdata, seed_word, mix, y, twist_word, tempered, abs_word;
  logic                re, we, go, finish, accept;

  assign go      = !pending || !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && go;
  assign accept  = in_valid && in_ready;
  assign finish  = (state == ST_IDLE) && pending && go;
  assign pos_adv = pending ? mtr_pkg::next_pos(pos) : pos;

  assign mix       = prev ^ (prev >> 30);
  assign seed_word = (idx == '0) ? seed_reg : mix * mtr_pkg::INIT_MULT + 32'(idx);

  assign y          = (cur & mtr_pkg::UPPER_BIT) | (nxt & mtr_pkg::LOWER_BITS);
  assign twist_word = rdata_a ^ (y >> 1) ^ (y[0] ? mtr_pkg::TWIST_XOR : '0);
  assign tempered   = mtr_pkg::temper(twist_word);
  assign abs_word   = tempered[31] ? ~tempered + 32'd1 : tempered;

  always_comb begin
    we    = (state == ST_SEED) || finish;
    waddr = (state == ST_SEED) ? idx : pos;
    wdata = (state == ST_SEED) ? seed_word : twist_word;
  end

  always_comb begin
    re      = 1'b0;
    raddr_a = pos;
    unique case (state)
      ST_IDLE: begin
        re      = go;
        raddr_a = pos_adv;
      end
      ST_LOAD: begin
        re = 1'b1;
      end
      ST_FAR: begin
        re      = 1'b1;
        raddr_a = mtr_pkg::far_pos(pos);
      end
      ST_SEED: begin
        re = 1'b0;
      end
      default: begin
        re = 1'b0;
      end
    endcase
    raddr_b = mtr_pkg::next_pos(raddr_a);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (reseed || !seeded) ? ST_SEED : ST_FAR;
        end
      end
      ST_SEED: begin
        if (idx == mtr_pkg::LAST_POS) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_FAR;
      ST_FAR:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      idx       <= '0;
      seeded    <= 1'b0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      seed_reg  <= mtr_pkg::SEED_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        seed_reg <= cfg_data;
      end
      if (out_valid && out_ready && !finish) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        pos       <= pos_adv;
        pending   <= 1'b0;
        out_valid <= 1'b1;
      end
      if (accept) begin
        idx <= '0;
      end
      if (state == ST_SEED) begin
        idx <= idx + mtr_pkg::AW'(1);
        if (idx == mtr_pkg::LAST_POS) begin
          pos    <= '0;
          seeded <= 1'b1;
        end
      end
      if (state == ST_FAR) begin
        pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEED) begin
      prev <= seed_word;
    end
    if (state == ST_FAR) begin
      cur <= rdata_a;
      nxt <= rdata_b;
    end
    if (finish) begin
      value <= abs_word;
    end
  end

  mtr_ram #(
    .WIDTH(32),
    .DEPTH(mtr_pkg::STATE_DEPTH)
  ) u_ram_a (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr_a),
    .rdata(rdata_a)
  );

  mtr_ram #(
    .WIDTH(32),
    .DEPTH(mtr_pkg::STATE_DEPTH)
  ) u_ram_b (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr_b),
    .rdata(rdata_b)
  );

endmodule

`default_nettype wire

@@ dv/mersenne_twister_rng_top_tb.sv @@
`timescale 1ns / 1ps

module mersenne_twister_rng_top_tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 300;
  localparam int RAND_PHASES = 5;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        reseed    = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;

  // generator shadow
  mtr_pkg::word_t mt_words [mtr_pkg::STATE_DEPTH];
  int unsigned    tap_pos   = 0;
  bit             primed    = 1'b0;
  mtr_pkg::word_t seed_copy = mtr_pkg::SEED_RESET;

  logic           reseed_q [$];
  mtr_pkg::word_t value_q  [$];
  int             errors = 0;

  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  int   send_gap = 0;
  bit   send_burst = 1'b0;
  int   hold_cycles = 0;
  bit   recv_burst = 1'b0;
  int   quiet_cycles = 0;

  mersenne_twister_rng_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .reseed   (reseed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value    (value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void load_seed();
    mtr_pkg::word_t prev;
    mt_words[0] = seed_copy;
    for (int i = 1; i < mtr_pkg::STATE_DEPTH; i++) begin
      prev = mt_words[i-1];
      mt_words[i] = mtr_pkg::INIT_MULT * (prev ^ (prev >> 30)) + mtr_pkg::word_t'(i);
    end
    tap_pos = 0;
    primed  = 1'b1;
  endfunction

  function automatic void twist_words();
    mtr_pkg::word_t mix;
    mtr_pkg::word_t nxt;
    for (int i = 0; i < mtr_pkg::STATE_DEPTH; i++) begin
      mix = (mt_words[i] & mtr_pkg::UPPER_BIT) |
            (mt_words[(i + 1) % mtr_pkg::STATE_DEPTH] & mtr_pkg::LOWER_BITS);
      nxt = mt_words[(i + mtr_pkg::SHIFT_SPAN) % mtr_pkg::STATE_DEPTH] ^ (mix >> 1);
      if (mix[0]) nxt = nxt ^ mtr_pkg::TWIST_XOR;
      mt_words[i] = nxt;
    end
  endfunction

  function automatic mtr_pkg::word_t next_draw(input logic do_reseed);
    mtr_pkg::word_t y;
    if (!primed || do_reseed) load_seed();
    if (tap_pos == 0) twist_words();
    y = mt_words[tap_pos];
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtr_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtr_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    tap_pos = (tap_pos == mtr_pkg::STATE_DEPTH - 1) ? 0 : tap_pos + 1;
    if (y[31]) y = ~y + 32'd1;
    return y;
  endfunction

  // input driver: hold the beat until accepted, then idle per the drawn gap
  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!in_valid || in_fire) begin
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
      end else if (reseed_q.size() > 0) begin
        reseed <= reseed_q.pop_front();
        next_valid = 1'b1;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 18);
      end
    end
    in_valid <= next_valid;
  end

  // output stall
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        hold_cycles = recv_burst ? 0 : $urandom_range(0, 18);
      end
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    mtr_pkg::word_t want;
    in_fire  <= !rst && in_valid && in_ready;
    out_fire <= !rst && out_valid && out_ready;
    if (!rst && in_valid && in_ready) value_q.push_back(next_draw(reseed));
    if (!rst && out_valid && out_ready) begin
      if (value_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected beat, expected none, got value %0d", $time, value);
      end else begin
        want = value_q.pop_front();
        if (value !== want) begin
          errors = errors + 1;
          $display("%0t: value mismatch, expected %0d, got %0d", $time, want, value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (reseed_q.size() != 0 || in_valid || value_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_seed(input mtr_pkg::word_t s);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= s;
    @(negedge clk);
    cfg_we   <= 1'b0;
    seed_copy = s;
  endtask

  task automatic queue_draws(input int n, input int reseed_odds);
    for (int i = 0; i < n; i++)
      reseed_q.push_back(reseed_odds > 0 && $urandom_range(1, reseed_odds) == 1);
  endtask

  initial begin
    mtr_pkg::word_t next_seed;
    int             odds;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unseeded first draw, then reseeds while seeded, back to back too
    reseed_q = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    wait_idle();
    write_seed(32'h0000_0000);
    reseed_q = '{1'b1, 1'b0, 1'b0, 1'b0};
    wait_idle();
    write_seed(32'hFFFF_FFFF);
    reseed_q = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_idle();
    write_seed(mtr_pkg::SEED_RESET);
    reseed_q = '{1'b1, 1'b0, 1'b1, 1'b0};

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0:       next_seed = 32'h0000_0000;
        1:       next_seed = 32'hFFFF_FFFF;
        2:       next_seed = mtr_pkg::SEED_RESET;
        default: next_seed = $urandom;
      endcase
      write_seed(next_seed);
      case ($urandom_range(0, 2))
        0:       odds = 0;
        1:       odds = 200;
        default: odds = 16;
      endcase
      queue_draws(PHASE_ITEMS / 2, odds);
      wait_idle();
      queue_draws(PHASE_ITEMS - PHASE_ITEMS / 2, odds);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
